FILE: hw/rtl/wzaf_pkg.sv
// ----------------------------------------------------------------------------
// wzaf_pkg
// Shared widths, register indexes, datapath operations and the control and
// status structs of the windowed z-score anomaly flagger.
// ----------------------------------------------------------------------------
package wzaf_pkg;

    // window and segment geometry
    localparam int WIN_DEPTH   = 16;
    localparam int HEAD_W      = 4;
    localparam int FILL_W      = 5;
    localparam int SEG_COUNT   = 256;
    localparam int SEG_W       = 8;
    localparam int SLOT_W      = SEG_W + HEAD_W;
    localparam int SLOT_COUNT  = SEG_COUNT * WIN_DEPTH;

    // arithmetic widths
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 20;
    localparam int SQ_W        = 36;
    localparam int LHS_W       = 41;
    localparam int RHS_W       = 40;
    localparam int VAR_W       = 41;
    localparam int NS_W        = 21;
    localparam int AD_W        = 20;
    localparam int XX_W        = 56;
    localparam int Q_W         = 30;
    localparam int DSH_W       = VAR_W + Q_W - 1;
    localparam int SATCMP_W    = VAR_W + Q_W;
    localparam int ZCHK_W      = 55;
    localparam int ROOT_W      = 30;
    localparam int CNT_W       = 5;

    // iteration counts
    localparam int DIV_STEPS   = 30;
    localparam int MEAN_STEPS  = 20;
    localparam int SQRT_STEPS  = 15;

    // spread threshold: sigma > 0.001 tested as var*15625 > n*n*1024
    localparam int SPREAD_MUL  = 15625;
    localparam int SPREAD_SHF  = 10;

    // configuration register indexes
    localparam logic [7:0] CFG_FREE_FLOW  = 8'd0;
    localparam logic [7:0] CFG_HOT_RATIO  = 8'd1;
    localparam logic [7:0] CFG_ANOM_THR   = 8'd2;

    // configuration reset values
    localparam logic [15:0] FREE_FLOW_RST = 16'd15360;
    localparam logic [8:0]  HOT_RATIO_RST = 9'd128;
    localparam logic [15:0] ANOM_THR_RST  = 16'hFE00;

    // per-segment bookkeeping entry
    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [FILL_W-1:0] fill;
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sq;
    } t_meta;

    // configuration values
    typedef struct packed {
        logic [15:0]        free_flow;
        logic [8:0]         hot_ratio;
        logic signed [15:0] anom_thr;
    } t_cfg;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_META,
        OP_UPDATE,
        OP_MUL,
        OP_VAR,
        OP_SQR,
        OP_PREP,
        OP_DIV,
        OP_SQRT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic iter_last;
    } t_dp_status;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_META,
        ST_UPDATE,
        ST_MUL,
        ST_VAR,
        ST_SQR,
        ST_PREP,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/wzaf_dp.sv
// ----------------------------------------------------------------------------
// wzaf_dp
// Datapath: sample ring memory, per-segment bookkeeping memory, statistics
// multipliers, a bit-serial divider, a bit-pair square root and result regs.
// ----------------------------------------------------------------------------
module wzaf_dp
    import wzaf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  t_cfg                 i_cfg,
    input  logic [SEG_W-1:0]     i_segment_index,
    input  logic [SAMPLE_W-1:0]  i_speed_sample,
    output logic [SEG_W-1:0]     o_segment_echo,
    output logic [15:0]          o_mean_speed,
    output logic [15:0]          o_delay_value,
    output logic signed [15:0]   o_z_value,
    output logic                 o_hotspot_flag,
    output logic                 o_anomaly_flag
);

    // memories
    logic [SAMPLE_W-1:0] r_smem [SLOT_COUNT];
    t_meta               r_mmem [SEG_COUNT];
    logic [SEG_COUNT-1:0] r_mvld;

    // item registers
    logic [SEG_W-1:0]    r_seg;
    logic [SAMPLE_W-1:0] r_s;
    t_meta               r_mrd;
    logic                r_mrd_vld;
    logic [HEAD_W-1:0]   r_head;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]     r_sq;
    logic [SAMPLE_W-1:0] r_old;
    logic [LHS_W-1:0]    r_lhs;
    logic [RHS_W-1:0]    r_rhs;
    logic [NS_W-1:0]     r_ns;
    logic [VAR_W-1:0]    r_var;
    logic                r_neg;
    logic [AD_W-1:0]     r_ad;
    logic [XX_W-1:0]     r_xx;
    logic                r_nz;
    logic                r_sat;
    logic [XX_W-1:0]     r_rem;
    logic [DSH_W-1:0]    r_dsh;
    logic [Q_W-1:0]      r_q;
    logic [CNT_W-1:0]    r_cnt;
    logic [FILL_W-1:0]   r_mrem;
    logic [SUM_W-1:0]    r_msh;
    logic [SUM_W-1:0]    r_mq;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_bit;

    // combinational helpers
    t_meta               meta_eff;
    logic                full;
    logic [FILL_W-1:0]   n_fill;
    logic [SUM_W-1:0]    n_sum;
    logic [SQ_W-1:0]     n_sq;
    logic [SQ_W-1:0]     old_sq;
    logic [SQ_W-1:0]     new_sq;
    logic [SUM_W-1:0]    old_term;
    logic [27:0]         x_val;
    logic [ZCHK_W-1:0]   spread_lhs;
    logic [ZCHK_W-1:0]   spread_rhs;
    logic                div_ge;
    logic [FILL_W:0]     mean_t;
    logic                mean_ge;
    logic [ROOT_W-1:0]   root_try;
    logic                root_ge;
    logic [14:0]         k_val;
    logic signed [15:0]  z_val;
    logic [24:0]         hot_lim;
    logic [23:0]         hot_s;

    // bookkeeping read as zero until first written
    always_comb begin
        meta_eff = r_mrd_vld ? r_mrd : '0;
    end

    // window update arithmetic
    always_comb begin
        full     = (r_fill == FILL_W'(WIN_DEPTH));
        n_fill   = full ? r_fill : r_fill + FILL_W'(1);
        old_term = full ? SUM_W'(r_old) : '0;
        old_sq   = full ? SQ_W'(r_old) * SQ_W'(r_old) : '0;
        new_sq   = SQ_W'(r_s) * SQ_W'(r_s);
        n_sum    = r_sum - old_term + SUM_W'(r_s);
        n_sq     = r_sq - old_sq + new_sq;
    end

    // spread test and divider, mean division and square root steps
    always_comb begin
        x_val      = {r_ad, 8'd0};
        spread_lhs = ZCHK_W'(r_var * ZCHK_W'(SPREAD_MUL));
        spread_rhs = ZCHK_W'(10'(r_fill) * 10'(r_fill)) << SPREAD_SHF;
        div_ge     = ({{(DSH_W-XX_W){1'b0}}, r_rem} >= r_dsh);
        mean_t     = {r_mrem, r_msh[SUM_W-1]};
        mean_ge    = (mean_t >= {1'b0, r_fill});
        root_try   = r_root + r_bit;
        root_ge    = (r_q >= root_try);
    end

    // result formatting
    always_comb begin
        k_val = r_root[14:0];
        if (!r_nz) begin
            z_val = '0;
        end else if (r_sat) begin
            z_val = r_neg ? 16'sh8000 : 16'sh7FFF;
        end else if (r_neg) begin
            z_val = -$signed({1'b0, k_val});
        end else begin
            z_val = $signed({1'b0, k_val});
        end
        hot_lim = 25'(i_cfg.free_flow) * 25'(i_cfg.hot_ratio);
        hot_s   = {r_s, 8'd0};
    end

    // sample ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_META) begin
            r_old <= r_smem[{r_seg, meta_eff.head}];
        end
        if (i_cmd.op == OP_UPDATE) begin
            r_smem[{r_seg, r_head}] <= r_s;
        end
    end

    // bookkeeping memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mrd <= r_mmem[i_segment_index];
        end
        if (i_cmd.op == OP_UPDATE) begin
            r_mmem[r_seg] <= '{head: r_head + HEAD_W'(1), fill: n_fill,
                               sum: n_sum, sq: n_sq};
        end
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld    <= '0;
            r_mrd_vld <= 1'b0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_mrd_vld <= r_mvld[i_segment_index];
            end
            if (i_cmd.op == OP_UPDATE) begin
                r_mvld[r_seg] <= 1'b1;
            end
        end
    end

    // operation sequence
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_seg <= i_segment_index;
                r_s   <= i_speed_sample;
            end
            OP_META: begin
                r_head <= meta_eff.head;
                r_fill <= meta_eff.fill;
                r_sum  <= meta_eff.sum;
                r_sq   <= meta_eff.sq;
            end
            OP_UPDATE: begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_sq   <= n_sq;
            end
            OP_MUL: begin
                r_lhs <= LHS_W'(r_fill) * LHS_W'(r_sq);
                r_rhs <= RHS_W'(r_sum) * RHS_W'(r_sum);
                r_ns  <= NS_W'(r_fill) * NS_W'(r_s);
            end
            OP_VAR: begin
                r_var <= (r_lhs > LHS_W'(r_rhs)) ? r_lhs - LHS_W'(r_rhs) : '0;
                r_neg <= (r_ns < NS_W'(r_sum));
                r_ad  <= (r_ns < NS_W'(r_sum)) ? AD_W'(NS_W'(r_sum) - r_ns)
                                               : AD_W'(r_ns - NS_W'(r_sum));
            end
            OP_SQR: begin
                r_xx   <= XX_W'(x_val) * XX_W'(x_val);
                r_nz   <= (spread_lhs > spread_rhs);
                r_mrem <= '0;
                r_msh  <= r_sum;
                r_mq   <= '0;
            end
            OP_PREP: begin
                r_sat <= ({{(SATCMP_W-XX_W){1'b0}}, r_xx} >= {r_var, {Q_W{1'b0}}});
                r_rem <= r_xx;
                r_dsh <= {r_var, {(Q_W-1){1'b0}}};
                r_q   <= '0;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end
            OP_DIV: begin
                if (div_ge) begin
                    r_rem <= XX_W'({{(DSH_W-XX_W){1'b0}}, r_rem} - r_dsh);
                end
                r_q   <= {r_q[Q_W-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
                // mean division runs on the last steps of the same count
                if (r_cnt < CNT_W'(MEAN_STEPS)) begin
                    r_mrem <= mean_ge ? FILL_W'(mean_t - {1'b0, r_fill})
                                      : FILL_W'(mean_t);
                    r_mq   <= {r_mq[SUM_W-2:0], mean_ge};
                    r_msh  <= {r_msh[SUM_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_cnt  <= CNT_W'(SQRT_STEPS - 1);
                    r_root <= '0;
                    r_bit  <= ROOT_W'(1) << (Q_W - 2);
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            OP_SQRT: begin
                if (root_ge) begin
                    r_q    <= r_q - root_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_OUT: begin
                o_segment_echo <= r_seg;
                o_mean_speed   <= r_mq[15:0];
                o_delay_value  <= (i_cfg.free_flow > r_s) ? i_cfg.free_flow - r_s : '0;
                o_z_value      <= z_val;
                o_hotspot_flag <= ({1'b0, hot_s} < hot_lim);
                o_anomaly_flag <= (z_val < i_cfg.anom_thr);
            end
            default: begin
            end
        endcase
    end

    assign o_status.iter_last = (r_cnt == '0);

endmodule

FILE: hw/rtl/wzaf_ctrl.sv
// ----------------------------------------------------------------------------
// wzaf_ctrl
// Controller: steps the datapath through one item and owns both handshakes
// of the input and result channels.
// ----------------------------------------------------------------------------
module wzaf_ctrl
    import wzaf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_META;
                end
            end
            ST_META: begin
                o_cmd.op = OP_META;
                n_state  = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_VAR;
            end
            ST_VAR: begin
                o_cmd.op = OP_VAR;
                n_state  = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.op = OP_SQR;
                n_state  = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_status.iter_last) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_status.iter_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // load the result register once the previous transfer is gone
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/windowed_zscore_anomaly_flagger.sv
// ----------------------------------------------------------------------------
// windowed_zscore_anomaly_flagger
// Per-segment sliding window statistics of speed samples with z-score,
// hotspot and anomaly flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one segment index and one
//   Q8.8 speed sample per transfer; each transfer yields exactly one result
//   on the output channel (o_out_valid/i_out_ready).
//   Configuration channel (i_cfg_valid/o_cfg_ready) writes free-flow speed,
//   hotspot ratio and anomaly threshold by index; it is always ready and
//   should be used while no item is in flight.
//   Each item runs through the 30-step serial divider and then the 15-step
//   square root; the next input is accepted only after that item's result
//   has been loaded into the output register.
//   A finished result sits in the output register; a new item is accepted
//   while it waits, and only the final load stalls if the receiver does.
//   Reset clears all segment windows at once and restores the default
//   configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
module windowed_zscore_anomaly_flagger
    import wzaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_segment_index,
    input  logic [15:0]         i_speed_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_segment_echo,
    output logic [15:0]         o_mean_speed,
    output logic [15:0]         o_delay_value,
    output logic signed [15:0]  o_z_value,
    output logic                o_hotspot_flag,
    output logic                o_anomaly_flag,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.free_flow <= FREE_FLOW_RST;
            r_cfg.hot_ratio <= HOT_RATIO_RST;
            r_cfg.anom_thr  <= ANOM_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FREE_FLOW: r_cfg.free_flow <= i_cfg_data;
                CFG_HOT_RATIO: r_cfg.hot_ratio <= i_cfg_data[8:0];
                CFG_ANOM_THR:  r_cfg.anom_thr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // controller
    wzaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // datapath
    wzaf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg           (r_cfg),
        .i_segment_index (i_segment_index),
        .i_speed_sample  (i_speed_sample),
        .o_segment_echo  (o_segment_echo),
        .o_mean_speed    (o_mean_speed),
        .o_delay_value   (o_delay_value),
        .o_z_value       (o_z_value),
        .o_hotspot_flag  (o_hotspot_flag),
        .o_anomaly_flag  (o_anomaly_flag)
    );

endmodule
